>>> rtl/assert_macros.svh
// assertion macros used by the checker file
// depends on nothing; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define ASSERT_IMPLY(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
    else $error("implication check failed");

// next-cycle implication, disabled while reset is low
`define ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

>>> rtl/csvt_pkg.sv
// types and constants of the csv field/row tokenizer
// used by all modules and the checker
package csvt_pkg;

  localparam int MaxRes = 6;
  localparam int ResCntW = $clog2(MaxRes + 1);
  localparam int QDepth = 4;
  localparam int QPtrW = $clog2(QDepth);
  localparam int QCntW = $clog2(QDepth + 1);

  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_CR = 8'h0D;

  typedef enum logic [1:0] {
    EV_CONTENT = 2'd0,
    EV_FIELD   = 2'd1,
    EV_ROW     = 2'd2,
    EV_DISCARD = 2'd3
  } ev_kind_t;

  typedef enum logic [4:0] {
    PS_UNQ    = 5'b00001,
    PS_UNQ_CR = 5'b00010,
    PS_QIN    = 5'b00100,
    PS_QQUOTE = 5'b01000,
    PS_QQCR   = 5'b10000
  } pstate_t;

  typedef struct packed {
    ev_kind_t   kind;
    logic [7:0] data;
    logic       is_null;
  } event_t;

  // all events caused by one input byte
  typedef struct packed {
    event_t [MaxRes-1:0]  ev;
    logic   [ResCntW-1:0] cnt;
  } bundle_t;

  function automatic event_t mk_ev(ev_kind_t kind, logic [7:0] data, logic is_null);
    event_t e;
    e.kind = kind;
    e.data = data;
    e.is_null = is_null;
    return e;
  endfunction

endpackage

>>> rtl/csvt_if.sv
// valid/ready channel interfaces for text input and event output
// depends on nothing
interface csvt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;
  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface csvt_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] event_kind;
  logic [7:0] content_byte;
  logic       field_is_null;
  logic       last_of_run;
  modport source (output valid, output event_kind, output content_byte,
                  output field_is_null, output last_of_run, input ready);
  modport sink (input valid, input event_kind, input content_byte,
                input field_is_null, input last_of_run, output ready);
endinterface

>>> rtl/csv_field_row_tokenizer_unit.sv
// Streaming CSV tokenizer: one text byte per input transaction, events out (content byte,
// field end, row end, discard of the partial field), one event per output transaction,
// with last_of_run marking the final event of each byte. The front end decodes a byte in
// the cycle it is accepted and can take a new byte every cycle while the four-entry bundle
// queue has room; a byte that yields no event reaches nothing downstream. The back end
// sends one event per cycle while the output is ready, so the sustained rate is set by the
// output side. When the path is empty, a bundle passes the queue's head register and the
// back end's bundle register before its first event appears at the output.
// depends on csvt_pkg, csvt_if, csvt_front, csvt_queue, csvt_back
module csv_field_row_tokenizer_unit (
  input  logic       clk,
  input  logic       rst_n,
  csvt_in_if.sink    in_ch,
  csvt_out_if.source out_ch
);

  logic push;
  csvt_pkg::bundle_t push_bundle;
  logic q_full;
  logic pop_valid;
  csvt_pkg::bundle_t pop_bundle;
  logic pop;

  csvt_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .q_full      (q_full),
    .push        (push),
    .push_bundle (push_bundle)
  );

  csvt_queue u_queue (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (push),
    .push_bundle (push_bundle),
    .full        (q_full),
    .pop_valid   (pop_valid),
    .pop_bundle  (pop_bundle),
    .pop         (pop)
  );

  csvt_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .pop_valid  (pop_valid),
    .pop_bundle (pop_bundle),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule

>>> rtl/csvt_front.sv
// front end: takes text bytes, runs the parse state and builds the event bundle
// depends on csvt_pkg and csvt_in_if
module csvt_front (
  input  logic              clk,
  input  logic              rst_n,
  csvt_in_if.sink           in_ch,
  input  logic              q_full,
  output logic              push,
  output csvt_pkg::bundle_t push_bundle
);

  csvt_pkg::pstate_t st_r, st_nxt;
  logic rmc_r, rmc_nxt;
  logic fhc_r, fhc_nxt;

  csvt_pkg::event_t [csvt_pkg::MaxRes-1:0] ev;
  logic [csvt_pkg::ResCntW-1:0] n;
  logic [7:0] c;
  logic do_unq;
  logic do_endline;
  logic accept;

  assign in_ch.ready = !q_full;
  assign accept = in_ch.valid && in_ch.ready;
  assign c = in_ch.text_byte;

  always_comb begin
    ev = '0;
    n = '0;
    st_nxt = st_r;
    rmc_nxt = rmc_r;
    fhc_nxt = fhc_r;
    do_unq = 1'b0;
    do_endline = 1'b0;

    unique case (st_r)
      csvt_pkg::PS_UNQ_CR: begin
        if (c == csvt_pkg::CH_LF) begin
          do_endline = 1'b1;
        end else begin
          ev[n] = csvt_pkg::mk_ev(csvt_pkg::EV_CONTENT, csvt_pkg::CH_CR, 1'b0);
          n = n + 1'b1;
          fhc_nxt = 1'b1;
          do_unq = 1'b1;
        end
      end
      csvt_pkg::PS_QIN: begin
        if (c == csvt_pkg::CH_QUOTE) begin
          st_nxt = csvt_pkg::PS_QQUOTE;
        end else begin
          ev[n] = csvt_pkg::mk_ev(csvt_pkg::EV_CONTENT, c, 1'b0);
          n = n + 1'b1;
        end
      end
      csvt_pkg::PS_QQUOTE: begin
        if (c == csvt_pkg::CH_QUOTE) begin
          ev[n] = csvt_pkg::mk_ev(csvt_pkg::EV_CONTENT, csvt_pkg::CH_QUOTE, 1'b0);
          n = n + 1'b1;
          st_nxt = csvt_pkg::PS_QIN;
        end else if (c == csvt_pkg::CH_COMMA) begin
          ev[n] = csvt_pkg::mk_ev(csvt_pkg::EV_FIELD, 8'd0, 1'b0);
          n = n + 1'b1;
          rmc_nxt = 1'b1;
          fhc_nxt = 1'b0;
          st_nxt = csvt_pkg::PS_UNQ;
        end else if (c == csvt_pkg::CH_LF) begin
          ev[n] = csvt_pkg::mk_ev(csvt_pkg::EV_FIELD, 8'd0, 1'b0);
          n = n + 1'b1;
          ev[n] = csvt_pkg::mk_ev(csvt_pkg::EV_ROW, 8'd0, 1'b0);
          n = n + 1'b1;
          rmc_nxt = 1'b0;
          fhc_nxt = 1'b0;
          st_nxt = csvt_pkg::PS_UNQ;
        end else if (c == csvt_pkg::CH_CR) begin
          st_nxt = csvt_pkg::PS_QQCR;
        end else begin
          // lone quote inside quotes is kept as text
          ev[n] = csvt_pkg::mk_ev(csvt_pkg::EV_CONTENT, csvt_pkg::CH_QUOTE, 1'b0);
          n = n + 1'b1;
          ev[n] = csvt_pkg::mk_ev(csvt_pkg::EV_CONTENT, c, 1'b0);
          n = n + 1'b1;
          st_nxt = csvt_pkg::PS_QIN;
        end
      end
      csvt_pkg::PS_QQCR: begin
        if (c == csvt_pkg::CH_LF) begin
          ev[n] = csvt_pkg::mk_ev(csvt_pkg::EV_FIELD, 8'd0, 1'b0);
          n = n + 1'b1;
          ev[n] = csvt_pkg::mk_ev(csvt_pkg::EV_ROW, 8'd0, 1'b0);
          n = n + 1'b1;
          rmc_nxt = 1'b0;
          fhc_nxt = 1'b0;
          st_nxt = csvt_pkg::PS_UNQ;
        end else begin
          ev[n] = csvt_pkg::mk_ev(csvt_pkg::EV_CONTENT, csvt_pkg::CH_QUOTE, 1'b0);
          n = n + 1'b1;
          ev[n] = csvt_pkg::mk_ev(csvt_pkg::EV_CONTENT, csvt_pkg::CH_CR, 1'b0);
          n = n + 1'b1;
          if (c == csvt_pkg::CH_QUOTE) begin
            st_nxt = csvt_pkg::PS_QQUOTE;
          end else begin
            ev[n] = csvt_pkg::mk_ev(csvt_pkg::EV_CONTENT, c, 1'b0);
            n = n + 1'b1;
            st_nxt = csvt_pkg::PS_QIN;
          end
        end
      end
      default: begin
        do_unq = 1'b1;
      end
    endcase

    // unquoted byte handling, also reached after a pending cr was flushed
    if (do_unq) begin
      if (c == csvt_pkg::CH_COMMA) begin
        ev[n] = csvt_pkg::mk_ev(csvt_pkg::EV_FIELD, 8'd0, !fhc_nxt);
        n = n + 1'b1;
        rmc_nxt = 1'b1;
        fhc_nxt = 1'b0;
        st_nxt = csvt_pkg::PS_UNQ;
      end else if (c == csvt_pkg::CH_QUOTE) begin
        if (fhc_nxt) begin
          ev[n] = csvt_pkg::mk_ev(csvt_pkg::EV_DISCARD, 8'd0, 1'b0);
          n = n + 1'b1;
        end
        fhc_nxt = 1'b0;
        st_nxt = csvt_pkg::PS_QIN;
      end else if (c == csvt_pkg::CH_LF) begin
        do_endline = 1'b1;
      end else if (c == csvt_pkg::CH_CR) begin
        st_nxt = csvt_pkg::PS_UNQ_CR;
      end else begin
        ev[n] = csvt_pkg::mk_ev(csvt_pkg::EV_CONTENT, c, 1'b0);
        n = n + 1'b1;
        fhc_nxt = 1'b1;
        st_nxt = csvt_pkg::PS_UNQ;
      end
    end

    if (do_endline) begin
      if (rmc_nxt || fhc_nxt) begin
        ev[n] = csvt_pkg::mk_ev(csvt_pkg::EV_FIELD, 8'd0, !fhc_nxt);
        n = n + 1'b1;
      end
      ev[n] = csvt_pkg::mk_ev(csvt_pkg::EV_ROW, 8'd0, 1'b0);
      n = n + 1'b1;
      rmc_nxt = 1'b0;
      fhc_nxt = 1'b0;
      st_nxt = csvt_pkg::PS_UNQ;
    end

    // end of text: flush pending bytes, close the open row, back to reset
    if (in_ch.end_of_text) begin
      if (st_nxt == csvt_pkg::PS_UNQ_CR) begin
        ev[n] = csvt_pkg::mk_ev(csvt_pkg::EV_CONTENT, csvt_pkg::CH_CR, 1'b0);
        n = n + 1'b1;
        fhc_nxt = 1'b1;
      end
      if (st_nxt == csvt_pkg::PS_QQCR) begin
        ev[n] = csvt_pkg::mk_ev(csvt_pkg::EV_CONTENT, csvt_pkg::CH_QUOTE, 1'b0);
        n = n + 1'b1;
        ev[n] = csvt_pkg::mk_ev(csvt_pkg::EV_CONTENT, csvt_pkg::CH_CR, 1'b0);
        n = n + 1'b1;
      end
      if (st_nxt == csvt_pkg::PS_QIN || st_nxt == csvt_pkg::PS_QQUOTE ||
          st_nxt == csvt_pkg::PS_QQCR || fhc_nxt) begin
        ev[n] = csvt_pkg::mk_ev(csvt_pkg::EV_FIELD, 8'd0, 1'b0);
        n = n + 1'b1;
        ev[n] = csvt_pkg::mk_ev(csvt_pkg::EV_ROW, 8'd0, 1'b0);
        n = n + 1'b1;
      end else if (rmc_nxt) begin
        ev[n] = csvt_pkg::mk_ev(csvt_pkg::EV_ROW, 8'd0, 1'b0);
        n = n + 1'b1;
      end
      st_nxt = csvt_pkg::PS_UNQ;
      rmc_nxt = 1'b0;
      fhc_nxt = 1'b0;
    end
  end

  assign push = accept && (n != '0);
  assign push_bundle.ev = ev;
  assign push_bundle.cnt = n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= csvt_pkg::PS_UNQ;
      rmc_r <= 1'b0;
      fhc_r <= 1'b0;
    end else if (accept) begin
      st_r <= st_nxt;
      rmc_r <= rmc_nxt;
      fhc_r <= fhc_nxt;
    end
  end

endmodule

>>> rtl/csvt_queue.sv
// bundle queue between front and back, with a registered head entry
// depends on csvt_pkg
module csvt_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  csvt_pkg::bundle_t push_bundle,
  output logic              full,
  output logic              pop_valid,
  output csvt_pkg::bundle_t pop_bundle,
  input  logic              pop
);

  csvt_pkg::bundle_t mem [csvt_pkg::QDepth];
  logic [csvt_pkg::QPtrW-1:0] wr_ptr_r, rd_ptr_r;
  logic [csvt_pkg::QCntW-1:0] cnt_r, cnt_nxt;
  logic head_v_r, head_v_nxt;
  csvt_pkg::bundle_t head_r;
  logic load_head, from_mem, bypass, wr_mem;

  function automatic logic [csvt_pkg::QPtrW-1:0] ptr_inc(logic [csvt_pkg::QPtrW-1:0] p);
    if (p == csvt_pkg::QPtrW'(csvt_pkg::QDepth - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  assign full = (cnt_r == csvt_pkg::QCntW'(csvt_pkg::QDepth));
  assign load_head = !head_v_r || pop;
  assign from_mem = load_head && (cnt_r != '0);
  // empty store, head free or being popped: a pushed bundle goes straight to the head
  assign bypass = load_head && (cnt_r == '0) && push;
  assign wr_mem = push && !bypass;

  always_comb begin
    cnt_nxt = cnt_r;
    if (wr_mem && !from_mem) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!wr_mem && from_mem) begin
      cnt_nxt = cnt_r - 1'b1;
    end
    head_v_nxt = load_head ? ((cnt_r != '0) || push) : 1'b1;
  end

  always_ff @(posedge clk) begin
    if (wr_mem) begin
      mem[wr_ptr_r] <= push_bundle;
    end
    if (from_mem) begin
      head_r <= mem[rd_ptr_r];
    end else if (bypass) begin
      head_r <= push_bundle;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r <= '0;
      head_v_r <= 1'b0;
    end else begin
      if (wr_mem) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (from_mem) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      cnt_r <= cnt_nxt;
      head_v_r <= head_v_nxt;
    end
  end

  assign pop_valid = head_v_r;
  assign pop_bundle = head_r;

endmodule

>>> rtl/csvt_back.sv
// back end: holds one bundle and hands its events out one per transaction
// depends on csvt_pkg and csvt_out_if
module csvt_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              pop_valid,
  input  csvt_pkg::bundle_t pop_bundle,
  output logic              pop,
  csvt_out_if.source        out_ch
);

  logic busy_r;
  csvt_pkg::bundle_t bund_r;
  logic [csvt_pkg::ResCntW-1:0] idx_r;
  csvt_pkg::event_t cur;
  logic last;
  logic fire;

  assign cur = bund_r.ev[idx_r];
  assign last = (idx_r == bund_r.cnt - 1'b1);
  assign fire = out_ch.valid && out_ch.ready;
  assign pop = pop_valid && (!busy_r || (fire && last));

  always_ff @(posedge clk) begin
    if (pop) begin
      bund_r <= pop_bundle;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r <= '0;
    end else if (pop) begin
      busy_r <= 1'b1;
      idx_r <= '0;
    end else if (fire) begin
      if (last) begin
        busy_r <= 1'b0;
        idx_r <= '0;
      end else begin
        idx_r <= idx_r + 1'b1;
      end
    end
  end

  assign out_ch.valid = busy_r;
  assign out_ch.event_kind = cur.kind;
  assign out_ch.content_byte = cur.data;
  assign out_ch.field_is_null = cur.is_null;
  assign out_ch.last_of_run = last;

endmodule

>>> rtl/csvt_checker.sv
// port-level checks on the tokenizer event output, bound to the top level
// depends on csvt_pkg and assert_macros.svh
`include "assert_macros.svh"

module csvt_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] event_kind,
  input logic [7:0] content_byte,
  input logic       field_is_null,
  input logic       last_of_run
);

  logic [11:0] payload;
  logic        holding;
  logic        ctrl_event;
  logic        null_flag;

  assign payload = {event_kind, content_byte, field_is_null, last_of_run};
  assign holding = out_valid && !out_ready;
  assign ctrl_event = out_valid && (event_kind != csvt_pkg::EV_CONTENT);
  assign null_flag = out_valid && field_is_null;

  `ASSERT_NEXT(a_valid_held, clk, rst_n, holding, out_valid)
  `ASSERT_NEXT(a_payload_held, clk, rst_n, holding, $stable(payload))
  // only content events carry a byte
  `ASSERT_IMPLY(a_byte_zero, clk, rst_n, ctrl_event, content_byte == 8'd0)
  // null flag belongs to field ends only
  `ASSERT_IMPLY(a_null_field, clk, rst_n, null_flag, event_kind == csvt_pkg::EV_FIELD)

endmodule

bind csv_field_row_tokenizer_unit csvt_checker u_csvt_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .event_kind    (out_ch.event_kind),
  .content_byte  (out_ch.content_byte),
  .field_is_null (out_ch.field_is_null),
  .last_of_run   (out_ch.last_of_run)
);
